[sv/stereo_disparity_point_distance_macros.svh]
// Assertion macros for the stereo disparity point distance block.
`ifndef STEREO_DISPARITY_POINT_DISTANCE_MACROS_SVH
`define STEREO_DISPARITY_POINT_DISTANCE_MACROS_SVH
// implication checked on every clock edge outside reset
`define SDPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SDPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/sdpd_pkg.sv]
// Package with constants, types and command structs for the stereo point block.
package sdpd_pkg;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int OUT_W   = 37;
    localparam int DIST_W  = 38;
    localparam int FX_W    = 20;
    localparam int CU_W    = 16;
    localparam int BL_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    // divider widths: dividend magnitude up to 58 bits, divisor up to 20 bits
    localparam int DIVN_W  = 58;
    localparam int DIVD_W  = 20;
    localparam int DIVN_CW = 6;
    // square-root radicand 78 bits, result 39 bits
    localparam int SQ_W    = 78;
    localparam int SQR_W   = 39;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_U = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_V = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 3'd4;

    localparam logic [FX_W-1:0] FOCAL_X_RST  = 20'd60660;
    localparam logic [FX_W-1:0] FOCAL_Y_RST  = 20'd60683;
    localparam logic [CU_W-1:0] CENTER_U_RST = 16'd11158;
    localparam logic [CU_W-1:0] CENTER_V_RST = 16'd9425;
    localparam logic [BL_W-1:0] BASELINE_RST = 16'd1534;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIVZ_START, OP_DIVZ_DONE, OP_MULX, OP_DIVX_START, OP_DIVX_DONE,
        OP_MULY, OP_DIVY_START, OP_DIVY_DONE, OP_SQ, OP_SQRT_START, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic second;
    } t_status;
endpackage

[sv/sdpd_divider.sv]
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module sdpd_divider
    import sdpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_neg,
    input  logic [DIVN_W-1:0]        i_num,
    input  logic [DIVD_W-1:0]        i_den,
    output logic                     o_done,
    output logic signed [DIVN_W:0]   o_quot
);
    logic [DIVN_W-1:0]  r_q;
    logic [DIVD_W:0]    r_rem;
    logic [DIVD_W-1:0]  r_den;
    logic [DIVN_CW-1:0] r_cnt;
    logic               r_busy;
    logic               r_neg;
    logic               r_done;
    logic [DIVD_W:0]    n_trial;
    logic [DIVD_W:0]    n_shift;

    always_comb begin
        n_shift = {r_rem[DIVD_W-1:0], r_q[DIVN_W-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_neg;
                r_cnt  <= DIVN_CW'(DIVN_W - 1);
            end else if (r_busy) begin
                if (!n_trial[DIVD_W]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[DIVN_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[DIVN_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
endmodule

[sv/sdpd_sqrt.sv]
// Bit-serial floor square root of an unsigned 78-bit radicand.
module sdpd_sqrt
    import sdpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_rad,
    output logic              o_done,
    output logic [SQR_W-1:0]  o_root
);
    logic [SQ_W-1:0]   r_rad;
    logic [SQR_W+1:0]  r_rem;
    logic [SQR_W-1:0]  r_root;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SQR_W+1:0]  n_shift;
    logic [SQR_W+1:0]  n_trial;

    always_comb begin
        n_shift = {r_rem[SQR_W-1:0], r_rad[SQ_W-1:SQ_W-2]};
        n_trial = n_shift - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'(SQR_W - 1);
            end else if (r_busy) begin
                r_rad <= {r_rad[SQ_W-3:0], 2'b00};
                if (!n_trial[SQR_W+1]) begin
                    r_rem  <= n_trial;
                    r_root <= {r_root[SQR_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_root <= {r_root[SQR_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[sv/sdpd_datapath.sv]
// Datapath: operand registers, multiplies, shared divider and square root.
module sdpd_datapath
    import sdpd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [COORD_BITS-1:0]    i_left_col,
    input  logic [COORD_BITS-1:0]    i_left_row,
    input  logic [COORD_BITS-1:0]    i_right_col,
    input  logic [FX_W-1:0]          i_focal_x,
    input  logic [FX_W-1:0]          i_focal_y,
    input  logic [CU_W-1:0]          i_center_u,
    input  logic [CU_W-1:0]          i_center_v,
    input  logic [BL_W-1:0]          i_baseline,
    output logic signed [OUT_W-1:0]  o_depth_z,
    output logic signed [OUT_W-1:0]  o_cam_x,
    output logic signed [OUT_W-1:0]  o_cam_y,
    output logic [DIST_W-1:0]        o_pair_distance,
    output logic                     o_zero_disparity,
    output logic                     o_saturated,
    output logic                     o_second_point
);
    localparam int DU_W = COORD_BITS + FRAC_BITS + 2;
    localparam logic signed [OUT_W:0] HI = {2'b00, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W:0] LO = {2'b11, {(OUT_W-1){1'b0}}};

    logic signed [DU_W-1:0]     r_du;
    logic signed [DU_W-1:0]     r_dv;
    logic signed [OUT_W-1:0]    r_z, r_x, r_y;
    logic signed [OUT_W-1:0]    r_fx, r_fy, r_fz;
    logic                       r_zero, r_sat, r_phase, r_second;
    logic [DIVN_W-1:0]          r_num;
    logic                       r_neg;
    logic [DIVD_W-1:0]          r_den;
    logic [SQ_W-1:0]            r_acc;
    logic [1:0]                 r_sq_idx;
    logic [DIST_W-1:0]          r_dist;

    logic                       w_div_done, w_sqrt_done;
    logic signed [DIVN_W:0]     w_quot;
    logic [SQR_W-1:0]           w_root;
    logic                       w_div_start;
    logic signed [COORD_BITS:0] w_disp;
    logic signed [OUT_W:0]      w_diff;
    logic [OUT_W-1:0]           w_mag;
    logic signed [DU_W+OUT_W-1:0] w_prod;
    logic signed [DU_W+OUT_W-1:0] w_pmag;

    sdpd_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_neg(r_neg),
        .i_num(r_num), .i_den(r_den), .o_done(w_div_done), .o_quot(w_quot)
    );

    sdpd_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.op == OP_SQRT_START),
        .i_rad(r_acc), .o_done(w_sqrt_done), .o_root(w_root)
    );

    assign w_div_start = (i_cmd.op == OP_DIVZ_START) || (i_cmd.op == OP_DIVX_START) ||
                         (i_cmd.op == OP_DIVY_START);

    // disparity of the item being accepted; depth operands are set up at load
    assign w_disp = $signed({1'b0, i_left_col}) - $signed({1'b0, i_right_col});

    // one signed multiply per MULX/MULY step
    always_comb begin
        w_prod = (i_cmd.op == OP_MULY) ? r_dv * r_z : r_du * r_z;
        w_pmag = w_prod < 0 ? -w_prod : w_prod;
        case (r_sq_idx)
            2'd0:    w_diff = $signed({r_x[OUT_W-1], r_x}) - $signed({r_fx[OUT_W-1], r_fx});
            2'd1:    w_diff = $signed({r_y[OUT_W-1], r_y}) - $signed({r_fy[OUT_W-1], r_fy});
            default: w_diff = $signed({r_z[OUT_W-1], r_z}) - $signed({r_fz[OUT_W-1], r_fz});
        endcase
        w_mag = w_diff < 0 ? OUT_W'(-w_diff) : OUT_W'(w_diff);
    end

    function automatic logic signed [OUT_W-1:0] clip(input logic signed [DIVN_W:0] v);
        if (v > HI)      return HI[OUT_W-1:0];
        else if (v < LO) return LO[OUT_W-1:0];
        else             return v[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_fx <= '0;
            r_fy <= '0;
            r_fz <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_zero   <= (i_left_col == i_right_col);
                    r_du     <= $signed(DU_W'(i_left_col) << FRAC_BITS) -
                                $signed(DU_W'(i_center_u));
                    r_dv     <= $signed(DU_W'(i_left_row) << FRAC_BITS) -
                                $signed(DU_W'(i_center_v));
                    r_num    <= DIVN_W'(i_baseline * i_focal_x);
                    r_neg    <= w_disp[COORD_BITS];
                    r_den    <= DIVD_W'(w_disp[COORD_BITS] ? -w_disp : w_disp);
                    r_sat    <= 1'b0;
                    r_second <= r_phase;
                    r_z <= '0;
                    r_x <= '0;
                    r_y <= '0;
                    r_acc <= '0;
                    r_sq_idx <= 2'd0;
                    r_dist <= '0;
                end
                OP_DIVZ_DONE: r_z <= w_quot[OUT_W-1:0];
                OP_MULX, OP_MULY: begin
                    r_num <= DIVN_W'(w_pmag);
                    r_neg <= w_prod < 0;
                    r_den <= (i_cmd.op == OP_MULY) ? i_focal_y : i_focal_x;
                end
                OP_DIVX_DONE: if (r_den != '0) begin
                    r_x <= clip(w_quot);
                    if (w_quot > HI || w_quot < LO) r_sat <= 1'b1;
                end
                OP_DIVY_DONE: if (r_den != '0) begin
                    r_y <= clip(w_quot);
                    if (w_quot > HI || w_quot < LO) r_sat <= 1'b1;
                end
                OP_SQ: begin
                    r_acc    <= r_acc + SQ_W'(w_mag * w_mag);
                    r_sq_idx <= r_sq_idx + 2'd1;
                end
                OP_FINISH: begin
                    if (!r_second) begin
                        r_fx <= r_x;
                        r_fy <= r_y;
                        r_fz <= r_z;
                    end
                    r_phase <= ~r_second;
                end
                default: ;
            endcase
            // root is ready before the finish step hands results out
            if (w_sqrt_done) r_dist <= w_root[DIST_W-1:0];
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.sqrt_done = w_sqrt_done;
    assign o_status.second    = r_second;
    assign o_depth_z  = r_z;
    assign o_cam_x    = r_x;
    assign o_cam_y    = r_y;
    assign o_pair_distance  = r_dist;
    assign o_zero_disparity = r_zero;
    assign o_saturated      = r_sat;
    assign o_second_point   = r_second;
endmodule

[sv/sdpd_control.sv]
// Sequencer stepping one item through the shared divider and square root.
module sdpd_control
    import sdpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  logic    i_zero,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_out_set
);
`include "stereo_disparity_point_distance_macros.svh"
    typedef enum logic [3:0] {
        S_IDLE, S_DZ, S_WZ, S_MX, S_DX, S_WX, S_MY, S_DY, S_WY,
        S_SQ0, S_SQ1, S_SQ2, S_SQRT, S_WSQ, S_FIN
    } t_state;

    t_state r_state, n_state;
    t_op    n_op;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        n_op    = OP_NONE;
        case (r_state)
            S_IDLE: if (i_in_fire) begin
                n_op = OP_LOAD; n_state = S_DZ;
            end
            S_DZ: if (i_zero) n_state = i_status.second ? S_SQ0 : S_FIN;
                  else begin n_op = OP_DIVZ_START; n_state = S_WZ; end
            S_WZ: if (i_status.div_done) begin n_op = OP_DIVZ_DONE; n_state = S_MX; end
            S_MX: begin n_op = OP_MULX; n_state = S_DX; end
            S_DX: begin n_op = OP_DIVX_START; n_state = S_WX; end
            S_WX: if (i_status.div_done) begin n_op = OP_DIVX_DONE; n_state = S_MY; end
            S_MY: begin n_op = OP_MULY; n_state = S_DY; end
            S_DY: begin n_op = OP_DIVY_START; n_state = S_WY; end
            S_WY: if (i_status.div_done) begin
                n_op = OP_DIVY_DONE;
                n_state = i_status.second ? S_SQ0 : S_FIN;
            end
            S_SQ0: begin n_op = OP_SQ; n_state = S_SQ1; end
            S_SQ1: begin n_op = OP_SQ; n_state = S_SQ2; end
            S_SQ2: begin n_op = OP_SQ; n_state = S_SQRT; end
            S_SQRT: begin n_op = OP_SQRT_START; n_state = S_WSQ; end
            S_WSQ: if (i_status.sqrt_done) n_state = S_FIN;
            S_FIN: begin n_op = OP_FINISH; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in_fire) r_busy <= 1'b1;
            else if (r_state == S_FIN) r_busy <= 1'b0;
        end
    end

    assign o_cmd.op  = n_op;
    assign o_busy    = r_busy;
    assign o_out_set = (r_state == S_FIN);

    `SDPD_ASSERT_IMP(a_fire_idle, i_clk, i_rst_n, i_in_fire, r_state == S_IDLE)
    `SDPD_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, r_state == S_FIN, r_state == S_IDLE)
    `SDPD_ASSERT_IMP(a_busy_state, i_clk, i_rst_n, r_state != S_IDLE, r_busy)
endmodule

[sv/stereo_disparity_point_distance.sv]
// Top level: stereo point reprojection and point-pair distance.
//  channel | direction | handshake           | payload
//  in      | in        | i_in_valid/o_in_ready  | left_col, left_row, right_col
//  out     | out       | o_out_valid/i_out_ready| depth, cam x/y, flags, distance
//  cfg     | in        | i_cfg_valid/o_cfg_ready| index, data
// One item at a time: the result of an input transfer with a nonzero disparity
// takes three passes of the bit-serial divider plus the sequencing states, and a
// second point adds the squares and the 39-step square root.
// A zero disparity skips the divider; a second point still takes squares and root.
// Synchronous active-low reset restores default calibration and phase zero.
// A finished result sits in the output register; the next item is taken while it
// waits, and a later finished result is parked, blocking input, until it is taken.
module stereo_disparity_point_distance
    import sdpd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [COORD_BITS-1:0]    i_left_col,
    input  logic [COORD_BITS-1:0]    i_left_row,
    input  logic [COORD_BITS-1:0]    i_right_col,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_depth_z,
    output logic signed [OUT_W-1:0]  o_cam_x,
    output logic signed [OUT_W-1:0]  o_cam_y,
    output logic                     o_second_point,
    output logic [DIST_W-1:0]        o_pair_distance,
    output logic                     o_zero_disparity,
    output logic                     o_saturated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data
);
    logic [FX_W-1:0] r_focal_x, r_focal_y;
    logic [CU_W-1:0] r_center_u, r_center_v;
    logic [BL_W-1:0] r_baseline;
    logic            r_out_valid;
    logic            r_hold;   // item finished in datapath, output still occupied
    logic signed [OUT_W-1:0] r_z, r_x, r_y;
    logic [DIST_W-1:0] r_dist;
    logic r_sec, r_zd, r_sat;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy, w_out_set, w_in_fire;
    logic signed [OUT_W-1:0] w_z, w_x, w_y;
    logic [DIST_W-1:0] w_dist;
    logic w_sec, w_zd, w_sat;

    // input taken only when sequencer idle and no finished item is parked
    assign o_in_ready  = !w_busy && !r_hold;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_X_RST;
            r_focal_y  <= FOCAL_Y_RST;
            r_center_u <= CENTER_U_RST;
            r_center_v <= CENTER_V_RST;
            r_baseline <= BASELINE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                REG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                REG_CENTER_U: r_center_u <= i_cfg_data[CU_W-1:0];
                REG_CENTER_V: r_center_v <= i_cfg_data[CU_W-1:0];
                REG_BASELINE: r_baseline <= i_cfg_data[BL_W-1:0];
                default: ;
            endcase
        end
    end

    sdpd_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire), .i_zero(w_zd),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(w_busy), .o_out_set(w_out_set)
    );

    sdpd_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_left_col(i_left_col), .i_left_row(i_left_row), .i_right_col(i_right_col),
        .i_focal_x(r_focal_x), .i_focal_y(r_focal_y), .i_center_u(r_center_u),
        .i_center_v(r_center_v), .i_baseline(r_baseline),
        .o_depth_z(w_z), .o_cam_x(w_x), .o_cam_y(w_y), .o_pair_distance(w_dist),
        .o_zero_disparity(w_zd), .o_saturated(w_sat), .o_second_point(w_sec)
    );

    // Datapath holds results after FINISH until the next LOAD, which can only
    // happen once r_hold is clear, so parked results stay intact.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if ((w_out_set || r_hold) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
                r_hold      <= 1'b0;
                r_z <= w_z;  r_x <= w_x;  r_y <= w_y;
                r_dist <= w_dist;
                r_sec <= w_sec;  r_zd <= w_zd;  r_sat <= w_sat;
            end else if (w_out_set) begin
                r_hold <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_depth_z        = r_z;
    assign o_cam_x          = r_x;
    assign o_cam_y          = r_y;
    assign o_pair_distance  = r_dist;
    assign o_second_point   = r_sec;
    assign o_zero_disparity = r_zd;
    assign o_saturated      = r_sat;
endmodule

[dv/testbench.sv]
// Self-checking testbench for the stereo point reprojection and pair distance block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sdpd_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1130;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam int SETTLE = 300;
    // index outside the register list, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one expected result item
    typedef struct {
        logic signed [OUT_W-1:0] depth;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    second;
        logic [DIST_W-1:0]       pair_dist;
        logic                    zero;
        logic                    sat;
    } t_point_res;

    // directed row: pixel, optional hand-typed depth/flags
    typedef struct {
        int     col;
        int     row;
        int     rcol;
        bit     typed;
        longint depth;
        bit     zero;
    } t_point_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [CW-1:0] i_left_col = '0, i_left_row = '0, i_right_col = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_depth_z, o_cam_x, o_cam_y;
    logic o_second_point, o_zero_disparity, o_saturated;
    logic [DIST_W-1:0] o_pair_distance;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    stereo_disparity_point_distance uut (.*);

    // predictor state: calibration copy and stored first point
    longint cal_fx, cal_fy, cal_cu, cal_cv, cal_bl;
    bit     phase_second;
    longint pt_x, pt_y, pt_z;

    t_point_res expected_q[$];
    int  errors = 0;
    int  n_results = 0;
    int  n_zero = 0, n_sat = 0, n_pairs = 0;
    bit  rx_calm = 1'b0;
    int  rx_idle = 0;
    longint cycles = 0;

    function automatic longint clip37(longint v, ref bit sat);
        longint hi, lo;
        hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // floor sqrt of a 128-bit sum of squares
    function automatic logic [DIST_W-1:0] floor_root(logic [127:0] s);
        logic [127:0] r, c;
        r = '0;
        for (int b = DIST_W; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r[DIST_W-1:0];
    endfunction

    function automatic logic [127:0] square_of(longint d);
        logic [127:0] m;
        m = (d < 0) ? 128'(-d) : 128'(d);
        return m * m;
    endfunction

    function automatic t_point_res reproject(int col, int row, int rcol);
        t_point_res r;
        longint disp, z, x, y, du, dv;
        bit sat;
        disp = col - rcol;
        z = 0; x = 0; y = 0; sat = 1'b0;
        if (disp != 0) begin
            z  = clip37((cal_bl * cal_fx) / disp, sat);
            du = (longint'(col) <<< FB) - cal_cu;
            dv = (longint'(row) <<< FB) - cal_cv;
            if (cal_fx != 0) x = clip37((du * z) / cal_fx, sat);
            if (cal_fy != 0) y = clip37((dv * z) / cal_fy, sat);
        end
        r.pair_dist = '0;
        r.second = phase_second;
        if (phase_second)
            r.pair_dist = floor_root(square_of(x - pt_x) + square_of(y - pt_y)
                                     + square_of(z - pt_z));
        else begin
            pt_x = x; pt_y = y; pt_z = z;
        end
        phase_second = ~phase_second;
        r.depth = z; r.cx = x; r.cy = y;
        r.zero = (disp == 0);
        r.sat = sat;
        return r;
    endfunction

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DAT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FOCAL_X:  cal_fx = val & 20'hFFFFF;
            REG_FOCAL_Y:  cal_fy = val & 20'hFFFFF;
            REG_CENTER_U: cal_cu = val & 16'hFFFF;
            REG_CENTER_V: cal_cv = val & 16'hFFFF;
            REG_BASELINE: cal_bl = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic calibrate(longint fx, longint fy, longint cu, longint cv, longint bl);
        set_register(REG_FOCAL_X, fx);
        set_register(REG_FOCAL_Y, fy);
        set_register(REG_CENTER_U, cu);
        set_register(REG_CENTER_V, cv);
        set_register(REG_BASELINE, bl);
    endtask

    // wait for the block to drain before touching calibration
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // valid stays up between items unless an idle burst is taken
    task automatic send_point(int col, int row, int rcol, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_left_col  <= col[CW-1:0];
        i_left_row  <= row[CW-1:0];
        i_right_col <= rcol[CW-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        expected_q = {expected_q, reproject(col, row, rcol)};
    endtask

    // mostly small disparities keep depth large and exercise clipping
    task automatic random_point(bit gaps);
        int col, rcol;
        col = $urandom_range(0, 4095);
        case ($urandom_range(0, 5))
            0: rcol = col;
            1: rcol = $urandom_range(0, 4095);
            default: rcol = col - $urandom_range(1, 8) + $urandom_range(0, 16) / 2 * 0;
        endcase
        if (rcol < 0) rcol = col + 1;
        send_point(col, $urandom_range(0, 4095), rcol, gaps);
    endtask

    // receiver side: random stall bursts, none during the calm tail
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else if (rx_idle > 0)
            rx_idle--;
        else if (i_out_ready && $urandom_range(0, 3) == 0 && !rx_calm) begin
            i_out_ready <= 1'b0;
            rx_idle = $urandom_range(0, 2);
        end else if (!i_out_ready)
            i_out_ready <= 1'b1;
    end

    // result checker: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_point_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_depth_z !== e.depth) begin
                    $error("depth_z exp %0d got %0d", e.depth, o_depth_z); errors++;
                end
                if (o_cam_x !== e.cx) begin
                    $error("cam_x exp %0d got %0d", e.cx, o_cam_x); errors++;
                end
                if (o_cam_y !== e.cy) begin
                    $error("cam_y exp %0d got %0d", e.cy, o_cam_y); errors++;
                end
                if (o_second_point !== e.second) begin
                    $error("second_point exp %0d got %0d", e.second, o_second_point); errors++;
                end
                if (o_pair_distance !== e.pair_dist) begin
                    $error("pair_distance exp %0d got %0d", e.pair_dist, o_pair_distance);
                    errors++;
                end
                if (o_zero_disparity !== e.zero) begin
                    $error("zero_disparity exp %0d got %0d", e.zero, o_zero_disparity);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0d got %0d", e.sat, o_saturated); errors++;
                end
                n_zero += e.zero;
                n_sat  += e.sat;
                n_pairs += e.second;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    t_point_row dir_rows[] = '{
        // zero disparity at both corners: typed expectation
        '{0, 0, 0, 1, 0, 1},
        '{4095, 4095, 4095, 1, 0, 1},
        // extreme columns, largest and negative disparities
        '{4095, 0, 0, 0, 0, 0},
        '{0, 4095, 4095, 0, 0, 0},
        '{1, 1, 0, 0, 0, 0},
        '{4095, 4095, 4094, 0, 0, 0},
        '{0, 0, 1, 0, 0, 0},
        '{2048, 2048, 2047, 0, 0, 0},
        // a pair whose first point has zero disparity
        '{700, 500, 700, 1, 0, 1},
        '{700, 500, 650, 0, 0, 0},
        '{1000, 3000, 990, 0, 0, 0},
        '{1000, 3000, 1000, 1, 0, 1},
        '{2730, 1365, 2729, 0, 0, 0},
        '{1365, 2730, 1366, 0, 0, 0}
    };

    initial begin
        t_point_res chk;
        cal_fx = FOCAL_X_RST; cal_fy = FOCAL_Y_RST;
        cal_cu = CENTER_U_RST; cal_cv = CENTER_V_RST; cal_bl = BASELINE_RST;
        phase_second = 1'b0;
        pt_x = 0; pt_y = 0; pt_z = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset calibration
        foreach (dir_rows[i]) begin
            send_point(dir_rows[i].col, dir_rows[i].row, dir_rows[i].rcol, 1'b1);
            chk = expected_q[$];
            if (dir_rows[i].typed && (chk.depth != dir_rows[i].depth
                                      || chk.zero != dir_rows[i].zero)) begin
                $error("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end
        drain();

        // extremes of calibration, zero focals and an ignored index
        calibrate(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_register(REG_UNUSED, 20'hABCDE);
        send_point(0, 0, 1, 1'b0);
        send_point(4095, 4095, 4094, 1'b0);
        send_point(0, 4095, 4095, 1'b0);
        send_point(1, 0, 0, 1'b0);
        drain();
        calibrate(1, 1, 0, 0, 0);
        send_point(4095, 4095, 4000, 1'b0);
        send_point(10, 20, 5, 1'b0);
        drain();
        calibrate(0, 0, 0, 0, 65535);
        send_point(4095, 4095, 4094, 1'b0);
        send_point(100, 100, 99, 1'b0);
        drain();

        // random part over several calibrations; last block has no gaps
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: calibrate(FOCAL_X_RST, FOCAL_Y_RST, CENTER_U_RST, CENTER_V_RST,
                             BASELINE_RST);
                1: calibrate(1, 1, 65535, 65535, 65535);
                2: calibrate($urandom_range(1, 1048575), $urandom_range(1, 1048575),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
                3: calibrate(1048575, 1048575, 0, 0, 1);
                default: calibrate($urandom_range(1, 200), $urandom_range(1, 200),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
            endcase
            if (phase == 4) rx_calm = 1'b1;
            for (int n = 0; n < N_RANDOM / 5; n++)
                random_point(phase != 4);
            drain();
        end

        $display("covered %0d results: %0d pairs, %0d zero disparity, %0d saturated",
                 n_results, n_pairs, n_zero, n_sat);
        $display("calibration swept over reset, extreme, zero-focal and random settings");
        if (errors == 0 && expected_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/sdpd_pkg.sv
sv/sdpd_divider.sv
sv/sdpd_sqrt.sv
sv/sdpd_datapath.sv
sv/sdpd_control.sv
sv/stereo_disparity_point_distance.sv
dv/testbench.sv
